// File: rtl/core/ntcs_pkg.sv
package ntcs_pkg;

  localparam int unsigned ColorW    = 8;
  localparam int unsigned DistW     = 18;
  localparam int unsigned IdxW      = 8;

  localparam logic [IdxW-1:0] BasicLast = 8'd15;
  localparam logic [IdxW-1:0] ExtLast   = 8'd239;
  localparam logic [IdxW-1:0] CubeCount = 8'd216;
  localparam logic [IdxW-1:0] ExtOffset = 8'd16;

  localparam logic [ColorW-1:0] GreyFirst = 8'd8;
  localparam logic [ColorW-1:0] GreyStep  = 8'd10;

  localparam logic [6:0] CodeFgLo  = 7'd30;
  localparam logic [6:0] CodeBgLo  = 7'd40;
  localparam logic [6:0] CodeFgHi  = 7'd90;
  localparam logic [6:0] CodeBgHi  = 7'd100;
  localparam logic [6:0] CodeFgExt = 7'd38;
  localparam logic [6:0] CodeBgExt = 7'd48;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [1:0] {
    MODE_16   = 2'd0,
    MODE_256  = 2'd1,
    MODE_TRUE = 2'd2,
    MODE_NONE = 2'd3
  } palette_mode_e;

  typedef enum logic [1:0] {
    EXT_NONE    = 2'd0,
    EXT_INDEXED = 2'd1,
    EXT_DIRECT  = 2'd2
  } ext_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic [ColorW-1:0] b;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] r;
  } rgb_t;

  function automatic rgb_t basic_ref(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
      4'd1:    c = '{r: 8'd135, g: 8'd0,   b: 8'd0};
      4'd2:    c = '{r: 8'd0,   g: 8'd135, b: 8'd0};
      4'd3:    c = '{r: 8'd135, g: 8'd135, b: 8'd0};
      4'd4:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd135};
      4'd5:    c = '{r: 8'd135, g: 8'd0,   b: 8'd135};
      4'd6:    c = '{r: 8'd0,   g: 8'd135, b: 8'd135};
      4'd7:    c = '{r: 8'd192, g: 8'd192, b: 8'd192};
      4'd8:    c = '{r: 8'd135, g: 8'd135, b: 8'd135};
      4'd9:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      4'd10:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd11:   c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      4'd12:   c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd13:   c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      4'd14:   c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      default: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic [ColorW-1:0] cube_level(input logic [2:0] digit);
    logic [ColorW-1:0] v;
    case (digit)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/nearest_terminal_color_select.sv
// Nearest terminal color selector.
// Input channel s_axis: one beat per request. tdata holds red, green, blue;
// tuser holds the text layer flag and the palette mode.
// Output channel m_axis: one beat per request, except palette mode 3, which
// is accepted and dropped without a result.
// Sixteen-color and 256-color requests are answered by scanning the palette
// one entry per cycle through a single shared squared-distance pipeline
// (absolute difference, square, sum, compare). The palette entries are
// generated on the fly from index, cube digit and grey level counters.
// True-color requests bypass the scan and are loaded straight into the
// output register. One request is in work at a time; s_axis_tready_o
// stays low while a scan runs.
// Results leave through an output register: when the receiver stalls, the
// result is held and a finished scan waits for the register to drain.
// Reset (rst_ni low) empties the scan pipeline and the output register.
module nearest_terminal_color_select (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [ntcs_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] layer_is_back, [2:1] palette_mode
  input  logic [ntcs_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [6:0] lead_code, [14:7] palette_index, [22:15] out_red,
  // [30:23] out_green, [38:31] out_blue, [39] zero
  output logic [ntcs_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [1:0] extended_mode
  output logic [ntcs_pkg::OutUserW-1:0]   m_axis_tuser_o
);
  import ntcs_pkg::*;

  state_e            state_q, state_d;
  rgb_t              req_q;
  logic              back_q;
  palette_mode_e     mode_q;

  logic              issue_q, issue_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [2:0]        cr_q, cr_d, cg_q, cg_d, cb_q, cb_d;
  logic [ColorW-1:0] gv_q, gv_d;

  logic                   v1_q, v2_q, v3_q;
  logic [IdxW-1:0]        idx1_q, idx2_q, idx3_q;
  logic [ColorW-1:0]      dr1_q, dg1_q, db1_q;
  logic [2*ColorW-1:0]    sr2_q, sg2_q, sb2_q;
  logic [DistW-1:0]       dist3_q;
  logic [DistW-1:0]       best_d_q;
  logic [IdxW-1:0]        best_idx_q;

  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q;
  logic [OutUserW-1:0]    out_user_q;

  logic              in_acc;
  logic              slot_free;
  logic              load_true;
  logic              load_scan;
  logic              scan_start;
  palette_mode_e     in_mode;
  rgb_t              in_rgb;
  rgb_t              entry;
  logic [IdxW-1:0]   last_idx;
  logic              pipe_busy;
  logic [6:0]        basic_code;
  logic [IdxW-1:0]   ext_index;

  assign in_rgb  = '{r: s_axis_tdata_i[7:0], g: s_axis_tdata_i[15:8],
                     b: s_axis_tdata_i[23:16]};
  assign in_mode = palette_mode_e'(s_axis_tuser_i[2:1]);

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && slot_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_start      = in_acc && (in_mode inside {MODE_16, MODE_256});
  assign load_true       = in_acc && (in_mode == MODE_TRUE);
  assign load_scan       = (state_q == ST_FINISH) && slot_free;
  assign pipe_busy       = issue_q || v1_q || v2_q || v3_q;
  assign last_idx        = (mode_q == MODE_16) ? BasicLast : ExtLast;

  // Palette entry under the index counter
  always_comb begin
    if (mode_q == MODE_16) begin
      entry = basic_ref(idx_q[3:0]);
    end else if (idx_q < CubeCount) begin
      entry = '{r: cube_level(cr_q), g: cube_level(cg_q), b: cube_level(cb_q)};
    end else begin
      entry = '{r: gv_q, g: gv_q, b: gv_q};
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    idx_d   = idx_q;
    cr_d    = cr_q;
    cg_d    = cg_q;
    cb_d    = cb_q;
    gv_d    = gv_q;
    case (state_q)
      ST_IDLE: begin
        if (scan_start) begin
          state_d = ST_SCAN;
          issue_d = 1'b1;
          idx_d   = '0;
          cr_d    = '0;
          cg_d    = '0;
          cb_d    = '0;
          gv_d    = GreyFirst;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          if (idx_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
          // Blue digit fastest, red slowest
          if (cb_q == 3'd5) begin
            cb_d = '0;
            if (cg_q == 3'd5) begin
              cg_d = '0;
              cr_d = cr_q + 1'b1;
            end else begin
              cg_d = cg_q + 1'b1;
            end
          end else begin
            cb_d = cb_q + 1'b1;
          end
          if (idx_q >= CubeCount) begin
            gv_d = gv_q + GreyStep;
          end
        end else if (!pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      issue_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      v1_q    <= issue_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cr_q  <= cr_d;
    cg_q  <= cg_d;
    cb_q  <= cb_d;
    gv_q  <= gv_d;
    if (in_acc) begin
      req_q  <= in_rgb;
      back_q <= s_axis_tuser_i[0];
      mode_q <= in_mode;
    end
  end

  // Shared distance pipeline: difference, square, sum, compare
  always_ff @(posedge clk_i) begin
    idx1_q  <= idx_q;
    dr1_q   <= (entry.r > req_q.r) ? entry.r - req_q.r : req_q.r - entry.r;
    dg1_q   <= (entry.g > req_q.g) ? entry.g - req_q.g : req_q.g - entry.g;
    db1_q   <= (entry.b > req_q.b) ? entry.b - req_q.b : req_q.b - entry.b;
    idx2_q  <= idx1_q;
    sr2_q   <= dr1_q * dr1_q;
    sg2_q   <= dg1_q * dg1_q;
    sb2_q   <= db1_q * db1_q;
    idx3_q  <= idx2_q;
    dist3_q <= DistW'(sr2_q) + DistW'(sg2_q) + DistW'(sb2_q);
    if (scan_start) begin
      best_d_q   <= '1;
      best_idx_q <= '0;
    end else if (v3_q && (dist3_q < best_d_q)) begin
      // Strict compare keeps the lowest index on a tie
      best_d_q   <= dist3_q;
      best_idx_q <= idx3_q;
    end
  end

  always_comb begin
    if (best_idx_q[3]) begin
      basic_code = (back_q ? CodeBgHi : CodeFgHi) + {4'b0, best_idx_q[2:0]};
    end else begin
      basic_code = (back_q ? CodeBgLo : CodeFgLo) + {4'b0, best_idx_q[2:0]};
    end
    ext_index = best_idx_q + ExtOffset;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_true || load_scan) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_true) begin
      out_data_q <= {1'b0, in_rgb.b, in_rgb.g, in_rgb.r, 8'd0,
                     s_axis_tuser_i[0] ? CodeBgExt : CodeFgExt};
      out_user_q <= EXT_DIRECT;
    end else if (load_scan) begin
      if (mode_q == MODE_16) begin
        out_data_q <= {1'b0, 24'd0, 8'd0, basic_code};
        out_user_q <= EXT_NONE;
      end else begin
        out_data_q <= {1'b0, 24'd0, ext_index, back_q ? CodeBgExt : CodeFgExt};
        out_user_q <= EXT_INDEXED;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o)
    else $error("input ready while a scan is in work");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> !pipe_busy)
    else $error("scan finished with entries still in the pipeline");

  a_best_16_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && mode_q == MODE_16) |-> (best_idx_q <= BasicLast))
    else $error("sixteen-color winner out of range");

  a_best_256_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && mode_q == MODE_256) |-> (best_idx_q <= ExtLast))
    else $error("256-color winner out of range");

  a_scan_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !slot_free) |=> (state_q == ST_FINISH))
    else $error("scan result dropped while output stalled");
`endif

endmodule
